// File: src/sspf_pkg.sv
// sspf_pkg: shared types and constants for the serial status frame parser
// no dependencies; used by sspf_core and serial_status_frame_parser
`timescale 1ns / 1ps

package sspf_pkg;

   // parameter defaults
   localparam int MAX_PAYLOAD_DEF  = 8;
   localparam int COUNTER_BITS_DEF = 16;

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int ID_SLOTS   = 7;
   localparam int IDS_W      = BYTE_W * ID_SLOTS;
   localparam int PAYLOAD_W  = 64;
   localparam int PCOUNT_W   = 4;
   localparam int STAT_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = IDS_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_PATTERN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_TYPE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPTED_IDS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_FIELDS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_XOR_MODE      = 3'd4;

   localparam logic [BYTE_W-1:0] FIXED_FIELDS_RESET = 8'd4;
   localparam logic [BYTE_W-1:0] CHECKSUM_SEED      = 8'h00;

   // result word layout, lowest bit up
   localparam int RSP_ID_LSB    = 0;
   localparam int RSP_OK_LSB    = RSP_ID_LSB + BYTE_W;
   localparam int RSP_PL_LSB    = RSP_OK_LSB + 1;
   localparam int RSP_PC_LSB    = RSP_PL_LSB + PAYLOAD_W;
   localparam int RSP_FC_LSB    = RSP_PC_LSB + PCOUNT_W;
   localparam int RSP_RX_LSB    = RSP_FC_LSB + BYTE_W;
   localparam int RSP_CC_LSB    = RSP_RX_LSB + BYTE_W;
   localparam int RSP_GOOD_LSB  = RSP_CC_LSB + BYTE_W;
   localparam int RSP_BAD_LSB   = RSP_GOOD_LSB + STAT_W;
   localparam int RSP_USED_W    = RSP_BAD_LSB + STAT_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic [15:0]       start_pattern;
      logic [BYTE_W-1:0] status_type;
      logic [IDS_W-1:0]  accepted_ids;
      logic [BYTE_W-1:0] fixed_fields;
      logic              xor_mode;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    frame_id;
      logic                 checksum_ok;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [PCOUNT_W-1:0]  payload_count;
      logic [BYTE_W-1:0]    frame_counter_byte;
      logic [BYTE_W-1:0]    received_checksum;
      logic [BYTE_W-1:0]    computed_checksum;
      logic [STAT_W-1:0]    good_frames;
      logic [STAT_W-1:0]    bad_frames;
   } result_type;

endpackage

// File: src/sspf_core.sv
// sspf_core: frame parse state, payload store, running checksum and frame counters
// depends on sspf_pkg; at most one byte folded per step strobe
`timescale 1ns / 1ps

module sspf_core #(
   parameter int MAX_PAYLOAD  = sspf_pkg::MAX_PAYLOAD_DEF,
   parameter int COUNTER_BITS = sspf_pkg::COUNTER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [sspf_pkg::BYTE_W-1:0] rx_byte,
   input  sspf_pkg::cfg_type           cfg,
   output logic                        emit,
   output sspf_pkg::result_type        result
);

   localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
   localparam int SEL_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_SOF1, PH_SOF2, PH_LEN, PH_TYPE, PH_ID, PH_PAYLOAD, PH_COUNT, PH_CHECK
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [sspf_pkg::BYTE_W-1:0] length_ff, length_in;
   logic [sspf_pkg::BYTE_W-1:0] id_ff, id_in;
   logic [sspf_pkg::BYTE_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]            index_ff, index_in;
   logic [sspf_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [COUNTER_BITS-1:0]     good_ff, good_in;
   logic [COUNTER_BITS-1:0]     bad_ff, bad_in;
   logic [sspf_pkg::BYTE_W-1:0] store_ff [MAX_PAYLOAD];
   logic                        store_we;

   logic [sspf_pkg::BYTE_W-1:0] folded;
   logic signed [8:0]           plen_len;
   logic signed [8:0]           plen_cur;
   logic                        id_hit;
   logic [IDX_W-1:0]            index_inc;
   logic                        ok;
   logic [COUNTER_BITS-1:0]     good_inc, bad_inc;
   logic [sspf_pkg::PAYLOAD_W-1:0] packed_pl;

   always_comb begin
      if (cfg.xor_mode) begin
         folded = sum_ff ^ rx_byte;
      end else begin
         folded = sum_ff + rx_byte;
      end
      plen_len = $signed({1'b0, rx_byte}) - $signed({1'b0, cfg.fixed_fields});
      plen_cur = $signed({1'b0, length_ff}) - $signed({1'b0, cfg.fixed_fields});
      id_hit = 1'b0;
      for (int k = 0; k < sspf_pkg::ID_SLOTS; k++) begin
         if (cfg.accepted_ids[k*8 +: 8] == rx_byte) begin
            id_hit = 1'b1;
         end
      end
      index_inc = (index_ff < MAX_IDX) ? index_ff + 1'b1 : index_ff;
      ok        = (rx_byte == sum_ff);
      good_inc  = good_ff + 1'b1;
      bad_inc   = bad_ff + 1'b1;
      packed_pl = '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
         if (IDX_W'(i) < index_ff) begin
            packed_pl[i*8 +: 8] = store_ff[i];
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      id_in     = id_ff;
      count_in  = count_ff;
      index_in  = index_ff;
      sum_in    = sum_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      store_we  = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_SOF1: begin
               if (rx_byte == cfg.start_pattern[15:8]) begin
                  length_in = '0;
                  id_in     = '0;
                  count_in  = '0;
                  index_in  = '0;
                  sum_in    = rx_byte;
                  if (cfg.xor_mode) begin
                     sum_in = sspf_pkg::CHECKSUM_SEED ^ rx_byte;
                  end else begin
                     sum_in = sspf_pkg::CHECKSUM_SEED + rx_byte;
                  end
                  phase_in  = PH_SOF2;
               end
            end
            PH_SOF2: begin
               if (rx_byte == cfg.start_pattern[7:0]) begin
                  sum_in   = folded;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_SOF1;
               end
            end
            PH_LEN: begin
               length_in = rx_byte;
               if (plen_len < 9'sd1 || plen_len > 9'(MAX_PAYLOAD)) begin
                  phase_in = PH_SOF1;
               end else begin
                  sum_in   = folded;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (rx_byte == cfg.status_type) begin
                  sum_in   = folded;
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_SOF1;
               end
            end
            PH_ID: begin
               if (id_hit) begin
                  id_in    = rx_byte;
                  sum_in   = folded;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_SOF1;
               end
            end
            PH_PAYLOAD: begin
               store_we = (index_ff < MAX_IDX);
               index_in = index_inc;
               sum_in   = folded;
               if (plen_cur < 9'sd1 || $signed({5'b0, index_inc}) >= plen_cur
                   || index_inc >= MAX_IDX) begin
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               count_in = rx_byte;
               sum_in   = folded;
               phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (ok) begin
                  good_in = good_inc;
               end else begin
                  bad_in = bad_inc;
               end
               phase_in = PH_SOF1;
            end
            default: phase_in = PH_SOF1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SOF1;
         length_ff <= '0;
         id_ff     <= '0;
         count_ff  <= '0;
         index_ff  <= '0;
         sum_ff    <= sspf_pkg::CHECKSUM_SEED;
         good_ff   <= '0;
         bad_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         count_ff  <= count_in;
         index_ff  <= index_in;
         sum_ff    <= sum_in;
         good_ff   <= good_in;
         bad_ff    <= bad_in;
      end
   end

   // payload bytes, read only below the fill index
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[index_ff[SEL_W-1:0]] <= rx_byte;
      end
   end

   logic [31:0] good_wide, bad_wide;

   always_comb begin
      good_wide = 32'(ok ? good_inc : good_ff);
      bad_wide  = 32'(ok ? bad_ff : bad_inc);
      emit      = (phase_ff == PH_CHECK);
      result.frame_id           = id_ff;
      result.checksum_ok        = ok;
      result.payload_bytes      = packed_pl;
      result.payload_count      = sspf_pkg::PCOUNT_W'(index_ff);
      result.frame_counter_byte = count_ff;
      result.received_checksum  = rx_byte;
      result.computed_checksum  = sum_ff;
      result.good_frames        = good_wide[sspf_pkg::STAT_W-1:0];
      result.bad_frames         = bad_wide[sspf_pkg::STAT_W-1:0];
   end

endmodule

// File: src/serial_status_frame_parser.sv
// serial_status_frame_parser: top level with input byte register, result register
// and configuration registers; depends on sspf_pkg and sspf_core
//
//   channel   direction  payload
//   req_      in         rx_byte
//   rsp_      out        one result per frame, on its checksum byte
//   csr_      in         register writes, index 0 to 4
//
// one byte per cycle sustained while the result register can take a result; a byte that
// ends a frame passes the input register, then parse logic into the result register
// reset is synchronous and puts the parser back to hunting the first start byte
// only a checksum byte waits on a full result register; other bytes keep flowing
`timescale 1ns / 1ps

module serial_status_frame_parser #(
   parameter int MAX_PAYLOAD  = sspf_pkg::MAX_PAYLOAD_DEF,
   parameter int COUNTER_BITS = sspf_pkg::COUNTER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame_id, checksum_ok, payload_bytes, payload_count, frame_counter_byte,
   // received_checksum, computed_checksum, good_frames, bad_frames, zero pad
   output logic [sspf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [sspf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sspf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sspf_pkg::cfg_type              cfg_ff;
   logic                           in_valid_ff, in_valid_in;
   logic [sspf_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sspf_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                           emit;
   logic                           go;
   sspf_pkg::result_type           result;
   logic [sspf_pkg::RSP_DATA_W-1:0] rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pattern <= '0;
         cfg_ff.status_type   <= '0;
         cfg_ff.accepted_ids  <= '0;
         cfg_ff.fixed_fields  <= sspf_pkg::FIXED_FIELDS_RESET;
         cfg_ff.xor_mode      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            sspf_pkg::CSR_START_PATTERN: cfg_ff.start_pattern <= csr_wdata[15:0];
            sspf_pkg::CSR_STATUS_TYPE:   cfg_ff.status_type   <= csr_wdata[7:0];
            sspf_pkg::CSR_ACCEPTED_IDS:  cfg_ff.accepted_ids  <= csr_wdata;
            sspf_pkg::CSR_FIXED_FIELDS:  cfg_ff.fixed_fields  <= csr_wdata[7:0];
            sspf_pkg::CSR_XOR_MODE:      cfg_ff.xor_mode      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      go          = in_valid_ff && (!emit || !rsp_valid_ff || rsp_tready);
      req_tready  = !in_valid_ff || go;
      in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (go ? 1'b0 : in_valid_ff);
      if (go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   sspf_core #(
      .MAX_PAYLOAD  (MAX_PAYLOAD),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (go),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   always_comb begin
      rsp_word = '0;
      rsp_word[sspf_pkg::RSP_ID_LSB   +: 8]  = result.frame_id;
      rsp_word[sspf_pkg::RSP_OK_LSB]         = result.checksum_ok;
      rsp_word[sspf_pkg::RSP_PL_LSB   +: 64] = result.payload_bytes;
      rsp_word[sspf_pkg::RSP_PC_LSB   +: 4]  = result.payload_count;
      rsp_word[sspf_pkg::RSP_FC_LSB   +: 8]  = result.frame_counter_byte;
      rsp_word[sspf_pkg::RSP_RX_LSB   +: 8]  = result.received_checksum;
      rsp_word[sspf_pkg::RSP_CC_LSB   +: 8]  = result.computed_checksum;
      rsp_word[sspf_pkg::RSP_GOOD_LSB +: 16] = result.good_frames;
      rsp_word[sspf_pkg::RSP_BAD_LSB  +: 16] = result.bad_frames;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (go && emit) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: dv/tb_serial_status_frame_parser.sv
// tb_serial_status_frame_parser: self-checking bench that streams received bytes into the
// status frame parser and checks every frame result against a parse model kept in the bench
// depends on sspf_pkg and serial_status_frame_parser
`timescale 1ns / 1ps

module tb_serial_status_frame_parser;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_BYTES  = 120;

   typedef enum logic [2:0] {
      SEEK_SOF1, SEEK_SOF2, GET_LEN, GET_TYPE, GET_ID, GET_PAYLOAD, GET_COUNT, GET_CHECK
   } parse_phase_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sspf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [sspf_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [sspf_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // register shadow
   logic [15:0]                cfg_start     = '0;
   logic [7:0]                 cfg_type_code = '0;
   logic [sspf_pkg::IDS_W-1:0] cfg_ids       = '0;
   logic [7:0]                 cfg_fixed     = sspf_pkg::FIXED_FIELDS_RESET;
   logic                       cfg_xor       = 1'b0;

   // parse model state
   parse_phase_type phase    = SEEK_SOF1;
   logic [7:0]      len_q    = '0;
   logic [7:0]      id_q     = '0;
   logic [7:0]      count_q  = '0;
   logic [7:0]      sum_q    = sspf_pkg::CHECKSUM_SEED;
   logic [7:0]      pl_store [sspf_pkg::MAX_PAYLOAD_DEF];
   int              pl_idx   = 0;
   logic [15:0]     good_cnt = '0;
   logic [15:0]     bad_cnt  = '0;

   sspf_pkg::result_type pending_frames [$];
   logic [7:0]           frame_buf [$];
   int                   errors           = 0;
   int                   cycles           = 0;
   int                   frame_bytes_sent = 0;
   int                   send_idle_pct    = 0;
   int                   stall_pct        = 0;

   serial_status_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] fold_byte(input logic [7:0] acc, input logic [7:0] b);
      return cfg_xor ? (acc ^ b) : (acc + b);
   endfunction

   function automatic bit id_listed(input logic [7:0] b);
      for (int k = 0; k < sspf_pkg::ID_SLOTS; k++)
         if (cfg_ids[8*k +: 8] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int payload_len();
      return int'(len_q) - int'(cfg_fixed);
   endfunction

   // advance the parse model by one accepted word
   function automatic void parse_rx_byte(input logic [7:0] b);
      sspf_pkg::result_type r;
      int plen;
      case (phase)
         SEEK_SOF2: begin
            if (b == cfg_start[7:0]) begin
               sum_q = fold_byte(sum_q, b);
               phase = GET_LEN;
            end else
               phase = SEEK_SOF1;
         end
         GET_LEN: begin
            len_q = b;
            plen = payload_len();
            if (plen < 1 || plen > sspf_pkg::MAX_PAYLOAD_DEF)
               phase = SEEK_SOF1;
            else begin
               sum_q = fold_byte(sum_q, b);
               phase = GET_TYPE;
            end
         end
         GET_TYPE: begin
            if (b == cfg_type_code) begin
               sum_q = fold_byte(sum_q, b);
               phase = GET_ID;
            end else
               phase = SEEK_SOF1;
         end
         GET_ID: begin
            if (id_listed(b)) begin
               id_q = b;
               sum_q = fold_byte(sum_q, b);
               phase = GET_PAYLOAD;
            end else
               phase = SEEK_SOF1;
         end
         GET_PAYLOAD: begin
            if (pl_idx < sspf_pkg::MAX_PAYLOAD_DEF) begin
               pl_store[pl_idx] = b;
               pl_idx++;
            end
            sum_q = fold_byte(sum_q, b);
            plen = payload_len();
            if (plen < 1 || pl_idx >= plen || pl_idx >= sspf_pkg::MAX_PAYLOAD_DEF)
               phase = GET_COUNT;
         end
         GET_COUNT: begin
            count_q = b;
            sum_q = fold_byte(sum_q, b);
            phase = GET_CHECK;
         end
         GET_CHECK: begin
            r = '0;
            r.frame_id = id_q;
            r.checksum_ok = (b == sum_q);
            if (r.checksum_ok) good_cnt++;
            else bad_cnt++;
            for (int i = 0; i < pl_idx; i++) r.payload_bytes[8*i +: 8] = pl_store[i];
            r.payload_count = sspf_pkg::PCOUNT_W'(pl_idx);
            r.frame_counter_byte = count_q;
            r.received_checksum = b;
            r.computed_checksum = sum_q;
            r.good_frames = good_cnt;
            r.bad_frames = bad_cnt;
            pending_frames = {pending_frames, r};
            phase = SEEK_SOF1;
         end
         default: begin
            if (b == cfg_start[15:8]) begin
               len_q = '0;
               id_q = '0;
               count_q = '0;
               pl_idx = 0;
               sum_q = fold_byte(sspf_pkg::CHECKSUM_SEED, b);
               phase = SEEK_SOF2;
            end else
               phase = SEEK_SOF1;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      sspf_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: unexpected result word %h", $time, rsp_tdata);
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_id", 64'(want.frame_id),
                        64'(rsp_tdata[sspf_pkg::RSP_ID_LSB +: sspf_pkg::BYTE_W]));
            check_field("checksum_ok", 64'(want.checksum_ok),
                        64'(rsp_tdata[sspf_pkg::RSP_OK_LSB]));
            check_field("payload_bytes", want.payload_bytes,
                        rsp_tdata[sspf_pkg::RSP_PL_LSB +: sspf_pkg::PAYLOAD_W]);
            check_field("payload_count", 64'(want.payload_count),
                        64'(rsp_tdata[sspf_pkg::RSP_PC_LSB +: sspf_pkg::PCOUNT_W]));
            check_field("frame_counter_byte", 64'(want.frame_counter_byte),
                        64'(rsp_tdata[sspf_pkg::RSP_FC_LSB +: sspf_pkg::BYTE_W]));
            check_field("received_checksum", 64'(want.received_checksum),
                        64'(rsp_tdata[sspf_pkg::RSP_RX_LSB +: sspf_pkg::BYTE_W]));
            check_field("computed_checksum", 64'(want.computed_checksum),
                        64'(rsp_tdata[sspf_pkg::RSP_CC_LSB +: sspf_pkg::BYTE_W]));
            check_field("good_frames", 64'(want.good_frames),
                        64'(rsp_tdata[sspf_pkg::RSP_GOOD_LSB +: sspf_pkg::STAT_W]));
            check_field("bad_frames", 64'(want.bad_frames),
                        64'(rsp_tdata[sspf_pkg::RSP_BAD_LSB +: sspf_pkg::STAT_W]));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      parse_rx_byte(b);
   endtask

   task automatic send_buf();
      foreach (frame_buf[i]) send_byte(frame_buf[i]);
      frame_bytes_sent += frame_buf.size();
   endtask

   // stop the stream, let outstanding results drain and the input stage empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sspf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sspf_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sspf_pkg::CSR_START_PATTERN: cfg_start = val[15:0];
         sspf_pkg::CSR_STATUS_TYPE:   cfg_type_code = val[7:0];
         sspf_pkg::CSR_ACCEPTED_IDS:  cfg_ids = val[sspf_pkg::IDS_W-1:0];
         sspf_pkg::CSR_FIXED_FIELDS:  cfg_fixed = val[7:0];
         sspf_pkg::CSR_XOR_MODE:      cfg_xor = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] start, input logic [7:0] type_code,
                             input logic [sspf_pkg::IDS_W-1:0] ids, input logic [7:0] fixed,
                             input logic xor_mode);
      write_reg(sspf_pkg::CSR_START_PATTERN, sspf_pkg::CSR_DATA_W'(start));
      write_reg(sspf_pkg::CSR_STATUS_TYPE, sspf_pkg::CSR_DATA_W'(type_code));
      write_reg(sspf_pkg::CSR_ACCEPTED_IDS, sspf_pkg::CSR_DATA_W'(ids));
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(fixed));
      write_reg(sspf_pkg::CSR_XOR_MODE, sspf_pkg::CSR_DATA_W'(xor_mode));
   endtask

   // well-formed frame under the current registers; fill < 0 gives random payload
   function automatic void build_frame(input logic [7:0] id, input int plen,
                                       input bit good_sum, input int fill = -1);
      logic [7:0] acc;
      frame_buf = {};
      frame_buf = {frame_buf, cfg_start[15:8]};
      frame_buf = {frame_buf, cfg_start[7:0]};
      frame_buf = {frame_buf, 8'(plen) + cfg_fixed};
      frame_buf = {frame_buf, cfg_type_code};
      frame_buf = {frame_buf, id};
      repeat (plen + 1) frame_buf = {frame_buf, (fill < 0 ? 8'($urandom) : 8'(fill))};
      acc = sspf_pkg::CHECKSUM_SEED;
      foreach (frame_buf[i]) acc = fold_byte(acc, frame_buf[i]);
      frame_buf = {frame_buf, (good_sum ? acc : acc ^ 8'($urandom_range(255, 1)))};
   endfunction

   task automatic test_reset_values();
      build_frame(8'h00, 3, 1'b1);
      send_buf();
      build_frame(8'h00, 1, 1'b0);
      send_buf();
      wait_idle();
   endtask

   task automatic test_field_extremes();
      set_config(16'hFFFF, 8'hFF, '1, 8'd0, 1'b1);
      build_frame(8'hFF, sspf_pkg::MAX_PAYLOAD_DEF, 1'b1, 255);
      send_buf();
      build_frame(8'hFF, 1, 1'b0, 0);
      send_buf();
      wait_idle();
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(248));
      build_frame(8'hFF, 7, 1'b1);
      send_buf();
      wait_idle();
      // nothing can pass the length check here
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(255));
      frame_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_buf();
      wait_idle();
   endtask

   task automatic test_frame_aborts();
      set_config(16'h55AA, 8'h3C, 56'h27262524232221, 8'd4, 1'b0);
      // bad second start byte, then a start byte that must not restart the hunt
      frame_buf = {8'h55, 8'h55, 8'hAA};
      send_buf();
      build_frame(8'h21, 2, 1'b1);
      send_buf();
      // length giving zero, too many and negative payload
      frame_buf = {8'h55, 8'hAA, 8'h04, 8'h55, 8'hAA, 8'h0D, 8'h55, 8'hAA, 8'h03};
      send_buf();
      // wrong type, then unknown id
      frame_buf = {8'h55, 8'hAA, 8'h05, 8'h3D, 8'h55, 8'hAA, 8'h05, 8'h3C, 8'h20};
      send_buf();
      build_frame(8'h27, sspf_pkg::MAX_PAYLOAD_DEF, 1'b1);
      send_buf();
      wait_idle();
   endtask

   task automatic test_config_mid_frame();
      // payload length shrinks to the number of bytes already stored
      build_frame(8'h22, 5, 1'b1);
      for (int i = 0; i < 7; i++) send_byte(frame_buf[i]);
      wait_idle();
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(7));
      write_reg(sspf_pkg::CSR_XOR_MODE, sspf_pkg::CSR_DATA_W'(1));
      for (int i = 7; i < frame_buf.size(); i++) send_byte(frame_buf[i]);
      wait_idle();
      // payload length goes negative
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(4));
      write_reg(sspf_pkg::CSR_XOR_MODE, sspf_pkg::CSR_DATA_W'(0));
      build_frame(8'h23, 4, 1'b1);
      for (int i = 0; i < 6; i++) send_byte(frame_buf[i]);
      wait_idle();
      write_reg(sspf_pkg::CSR_FIXED_FIELDS, sspf_pkg::CSR_DATA_W'(200));
      for (int i = 6; i < frame_buf.size(); i++) send_byte(frame_buf[i]);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input logic [7:0] fixed);
      int pick;
      int max_len;
      send_idle_pct = idle;
      stall_pct = stall;
      set_config(16'($urandom), 8'($urandom), sspf_pkg::IDS_W'({$urandom, $urandom}), fixed,
                 1'($urandom));
      max_len = (255 - int'(fixed) < sspf_pkg::MAX_PAYLOAD_DEF) ? 255 - int'(fixed)
                                                                : sspf_pkg::MAX_PAYLOAD_DEF;
      frame_bytes_sent = 0;
      while (frame_bytes_sent < PHASE_BYTES) begin
         pick = $urandom_range(99);
         build_frame(cfg_ids[8*$urandom_range(sspf_pkg::ID_SLOTS-1) +: 8],
                     $urandom_range(max_len, 1), $urandom_range(9) != 0);
         if (pick < 12) begin
            // broken frame: cut short or spoil a header byte
            if ($urandom_range(1))
               frame_buf = frame_buf[0:$urandom_range(frame_buf.size() - 2)];
            else
               frame_buf[$urandom_range(4, 1)] ^= 8'($urandom_range(255, 1));
         end
         if (pick >= 88)
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
         else
            send_buf();
      end
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_extremes();
      test_frame_aborts();
      test_config_mid_frame();
      test_random_traffic(0, 0, 8'd0);
      test_random_traffic(67, 0, 8'd4);
      test_random_traffic(0, 67, 8'($urandom_range(247)));
      test_random_traffic(25, 25, 8'd247);
      if (errors == 0 && pending_frames.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
src/sspf_pkg.sv
src/sspf_core.sv
src/serial_status_frame_parser.sv
dv/tb_serial_status_frame_parser.sv
